// ===== rtl/core/timed_pose_sequencer_assert.svh =====
// Assertion macros shared by the sequencer RTL.
`ifndef TIMED_POSE_SEQUENCER_ASSERT_SVH
`define TIMED_POSE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, masked during reset.
`define TPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sequencer check failed");

// Next-cycle implication, sampled on clk_i, masked during reset.
`define TPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sequencer check failed");

`endif

// ===== rtl/core/tps_pkg.sv =====
package tps_pkg;

  localparam int MAX_STEPS = 16;
  localparam int PtrW      = $clog2(MAX_STEPS + 1);
  localparam int AddrW     = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int CountW    = 5;
  localparam int UseW      = (PtrW > CountW) ? PtrW : CountW;
  localparam int TimerW    = 32;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_RESTART = 2'd2
  } tps_cmd_e;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [15:0]        speed;
    logic [7:0]         accel;
    logic [15:0]        hold;
  } tps_entry_t;

endpackage

// ===== rtl/core/tps_if.sv =====
interface tps_in_if import tps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [3:0]         entry_index;
  logic signed [15:0] entry_left;
  logic signed [15:0] entry_right;
  logic [15:0]        entry_speed;
  logic [7:0]         entry_accel;
  logic [15:0]        entry_hold;
  logic [15:0]        tick_ms;

  modport source (output valid, cmd, entry_index, entry_left, entry_right, entry_speed,
                  entry_accel, entry_hold, tick_ms, input ready);
  modport sink   (input valid, cmd, entry_index, entry_left, entry_right, entry_speed,
                  entry_accel, entry_hold, tick_ms, output ready);
endinterface

interface tps_out_if import tps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               pose_valid;
  logic signed [15:0] pose_left;
  logic signed [15:0] pose_right;
  logic [15:0]        pose_speed;
  logic [7:0]         pose_accel;
  logic               seq_done;

  modport source (output valid, pose_valid, pose_left, pose_right, pose_speed, pose_accel,
                  seq_done, input ready);
  modport sink   (input valid, pose_valid, pose_left, pose_right, pose_speed, pose_accel,
                  seq_done, output ready);
endinterface

interface tps_cfg_if import tps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CountW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/core/timed_pose_sequencer.sv =====
// The accepting edge reads the table into rd_q and registers the command;
// S_EXEC then updates the timer and registers the result word, and waits
// there while the output is stalled.
// The input is held off while an item is in S_EXEC, its update state, so a
// new item is taken only once the current one has been registered out.
// Reset clears step pointer, step timer, step count and the output register;
// the pose table is not cleared and holds nothing valid until written.
`include "timed_pose_sequencer_assert.svh"

module timed_pose_sequencer import tps_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  tps_cfg_if.sink   cfg_i,
  tps_in_if.sink    in_i,
  tps_out_if.source pose_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;

  tps_entry_t pose_mem_q [MAX_STEPS];
  tps_entry_t rd_q;

  logic [CountW-1:0] step_count_q;
  logic [PtrW-1:0]   ptr_q, ptr_d;
  logic [TimerW-1:0] timer_q, timer_d;
  logic [1:0]        cmd_q;
  logic [15:0]       tick_q;

  logic               out_valid_q;
  logic               pose_valid_q, pose_valid_d;
  logic signed [15:0] pose_left_q, pose_left_d;
  logic signed [15:0] pose_right_q, pose_right_d;
  logic [15:0]        pose_speed_q, pose_speed_d;
  logic [7:0]         pose_accel_q, pose_accel_d;
  logic               seq_done_q, seq_done_d;

  logic              in_acc;
  logic              slot_free;
  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  tps_entry_t        wr_entry;
  logic [UseW-1:0]   used_steps;
  logic              finished;
  logic [TimerW:0]   sum;
  logic [TimerW-1:0] timer_sat;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign slot_free   = !out_valid_q || pose_o.ready;

  assign pose_o.valid      = out_valid_q;
  assign pose_o.pose_valid = pose_valid_q;
  assign pose_o.pose_left  = pose_left_q;
  assign pose_o.pose_right = pose_right_q;
  assign pose_o.pose_speed = pose_speed_q;
  assign pose_o.pose_accel = pose_accel_q;
  assign pose_o.seq_done   = seq_done_q;

  // Table writes land at accept, so any later tick reads them.
  assign wr_en   = in_acc && (in_i.cmd == CMD_WRITE) &&
                   (32'(in_i.entry_index) < 32'(MAX_STEPS));
  assign wr_addr = AddrW'(in_i.entry_index);
  assign wr_entry = '{left:  in_i.entry_left,  right: in_i.entry_right,
                      speed: in_i.entry_speed, accel: in_i.entry_accel,
                      hold:  in_i.entry_hold};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pose_mem_q[wr_addr] <= wr_entry;
    end
    if (in_acc && (in_i.cmd == CMD_TICK)) begin
      rd_q <= pose_mem_q[ptr_q[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q  <= in_i.cmd;
      tick_q <= in_i.tick_ms;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_count_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      step_count_q <= cfg_i.data;
    end
  end

  assign used_steps = (32'(step_count_q) > 32'(MAX_STEPS)) ? UseW'(MAX_STEPS)
                                                          : UseW'(step_count_q);
  assign finished   = (used_steps == '0) || (UseW'(ptr_q) >= used_steps);
  assign sum        = {1'b0, timer_q} + (TimerW + 1)'(tick_q);
  assign timer_sat  = sum[TimerW] ? '1 : sum[TimerW-1:0];

  always_comb begin
    ptr_d        = ptr_q;
    timer_d      = timer_q;
    pose_valid_d = 1'b0;
    pose_left_d  = '0;
    pose_right_d = '0;
    pose_speed_d = '0;
    pose_accel_d = '0;
    seq_done_d   = finished;
    case (cmd_q)
      CMD_TICK: begin
        if (!finished) begin
          if (timer_q == '0) begin
            pose_valid_d = 1'b1;
            pose_left_d  = rd_q.left;
            pose_right_d = rd_q.right;
            pose_speed_d = rd_q.speed;
            pose_accel_d = rd_q.accel;
          end
          if (timer_sat >= TimerW'(rd_q.hold)) begin
            timer_d = '0;
            ptr_d   = ptr_q + PtrW'(1);
          end else begin
            timer_d = timer_sat;
          end
          seq_done_d = (UseW'(ptr_d) >= used_steps);
        end
      end
      CMD_RESTART: begin
        ptr_d      = '0;
        timer_d    = '0;
        seq_done_d = (used_steps == '0);
      end
      default: begin
        seq_done_d = finished;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ptr_q        <= '0;
      timer_q      <= '0;
      out_valid_q  <= 1'b0;
      pose_valid_q <= 1'b0;
      pose_left_q  <= '0;
      pose_right_q <= '0;
      pose_speed_q <= '0;
      pose_accel_q <= '0;
      seq_done_q   <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (pose_o.ready) begin
            out_valid_q <= 1'b0;
          end
          if (in_acc) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          // hold the item until the output word is free
          if (slot_free) begin
            ptr_q        <= ptr_d;
            timer_q      <= timer_d;
            out_valid_q  <= 1'b1;
            pose_valid_q <= pose_valid_d;
            pose_left_q  <= pose_left_d;
            pose_right_q <= pose_right_d;
            pose_speed_q <= pose_speed_d;
            pose_accel_q <= pose_accel_d;
            seq_done_q   <= seq_done_d;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `TPS_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_i.ready)
  `TPS_ASSERT_NOW(a_no_pose_zero, out_valid_q && !pose_valid_q,
                  pose_left_q == '0 && pose_right_q == '0 && pose_speed_q == '0 &&
                  pose_accel_q == '0)
  `TPS_ASSERT_NOW(a_ptr_in_range, 1'b1, 32'(ptr_q) <= 32'(MAX_STEPS))

endmodule

// ===== tb/tb_timed_pose_sequencer.sv =====
`timescale 1ns / 100ps

module tb_timed_pose_sequencer;
  import tps_pkg::*;

  localparam logic [1:0]  CmdSpare      = 2'd3;
  localparam int unsigned QuietLimit    = 2000;
  localparam int unsigned ErrorPrintCap = 40;
  localparam int unsigned PhaseCount    = 13;
  localparam int unsigned PhaseItems    = 95;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  index;
    tps_entry_t  entry;
    logic [15:0] tick_ms;
  } seq_item_t;

  typedef struct packed {
    logic               pose_valid;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [15:0]        speed;
    logic [7:0]         accel;
    logic               done;
  } pose_word_t;

  logic clk_i;
  logic rst_ni;

  tps_cfg_if cfg_if ();
  tps_in_if  seq_in ();
  tps_out_if pose_out ();

  timed_pose_sequencer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (seq_in),
    .pose_o (pose_out)
  );

  // Own copy of the sequencer state
  tps_entry_t  pose_table [MAX_STEPS];
  logic [4:0]  step_ptr;
  logic [31:0] step_ms;
  logic [4:0]  step_total;

  pose_word_t  pending_poses [$];
  int unsigned errors          = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned stall_left      = 0;
  bit          sender_gaps     = 1'b1;
  bit          receiver_stalls = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [4:0] active_steps();
    return (step_total > 5'(MAX_STEPS)) ? 5'(MAX_STEPS) : step_total;
  endfunction

  function automatic bit run_over();
    return (active_steps() == '0) || (step_ptr >= active_steps());
  endfunction

  function automatic pose_word_t play_item(input seq_item_t it);
    pose_word_t  w;
    tps_entry_t  cur;
    logic [32:0] sum;
    w = '0;
    if (it.cmd == CMD_TICK) begin
      if (!run_over()) begin
        cur = pose_table[step_ptr[AddrW-1:0]];
        // issue the pose only while the step timer is still zero
        if (step_ms == '0) begin
          w.pose_valid = 1'b1;
          w.left       = cur.left;
          w.right      = cur.right;
          w.speed      = cur.speed;
          w.accel      = cur.accel;
        end
        sum     = {1'b0, step_ms} + {17'b0, it.tick_ms};
        step_ms = sum[32] ? '1 : sum[31:0];
        if (step_ms >= {16'b0, cur.hold}) begin
          step_ms  = '0;
          step_ptr = step_ptr + 5'd1;
        end
      end
    end else if (it.cmd == CMD_WRITE) begin
      pose_table[it.index] = it.entry;
    end else if (it.cmd == CMD_RESTART) begin
      step_ptr = '0;
      step_ms  = '0;
    end
    w.done = run_over();
    return w;
  endfunction

  function automatic seq_item_t make_item(input logic [1:0] cmd, input logic [3:0] index,
                                          input tps_entry_t entry, input logic [15:0] tick_ms);
    seq_item_t it;
    it.cmd     = cmd;
    it.index   = index;
    it.entry   = entry;
    it.tick_ms = tick_ms;
    return it;
  endfunction

  function automatic logic [15:0] pick_hold();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return '0;
    if (r < 70) return 16'($urandom_range(1, 60));
    if (r < 85) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_tick();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return 16'hFFFF;
    if (r < 80) return 16'($urandom_range(1, 40));
    return 16'($urandom);
  endfunction

  function automatic tps_entry_t random_entry();
    tps_entry_t e;
    e.left  = 16'($urandom);
    e.right = 16'($urandom);
    e.speed = 16'($urandom);
    e.accel = 8'($urandom);
    e.hold  = pick_hold();
    return e;
  endfunction

  function automatic seq_item_t random_item();
    seq_item_t   it;
    int unsigned r;
    it = make_item(CMD_TICK, 4'($urandom), random_entry(), pick_tick());
    r  = $urandom_range(0, 99);
    // favour a fresh run once the current one has finished
    if (run_over() && r < 40)  it.cmd = CMD_RESTART;
    else if (r < 70)           it.cmd = CMD_TICK;
    else if (r < 82)           it.cmd = CMD_WRITE;
    else if (r < 94)           it.cmd = CMD_RESTART;
    else                       it.cmd = CmdSpare;
    return it;
  endfunction

  task automatic send_item(input seq_item_t it);
    if (sender_gaps && $urandom_range(0, 7) == 0) begin
      seq_in.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    seq_in.valid       <= 1'b1;
    seq_in.cmd         <= it.cmd;
    seq_in.entry_index <= it.index;
    seq_in.entry_left  <= it.entry.left;
    seq_in.entry_right <= it.entry.right;
    seq_in.entry_speed <= it.entry.speed;
    seq_in.entry_accel <= it.entry.accel;
    seq_in.entry_hold  <= it.entry.hold;
    seq_in.tick_ms     <= it.tick_ms;
    do @(posedge clk_i); while (!seq_in.ready);
    pending_poses.push_back(play_item(it));
  endtask

  // Hold the sender until every expected word has come back
  task automatic drain_poses();
    seq_in.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_poses.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_step_count(input logic [4:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    step_total    = value;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= ErrorPrintCap)
        $display("%0t mismatch %s: expected %h, actual %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    pose_word_t want;
    if (rst_ni && pose_out.valid && pose_out.ready) begin
      if (pending_poses.size() == 0) begin
        errors++;
        if (errors <= ErrorPrintCap)
          $display("%0t unexpected pose word: expected none, actual valid=%b left=%h done=%b",
                   $time, pose_out.pose_valid, pose_out.pose_left, pose_out.seq_done);
      end else begin
        want = pending_poses.pop_front();
        check_field("pose_valid", 16'(want.pose_valid), 16'(pose_out.pose_valid));
        check_field("pose_left",  want.left,            pose_out.pose_left);
        check_field("pose_right", want.right,           pose_out.pose_right);
        check_field("pose_speed", want.speed,           pose_out.pose_speed);
        check_field("pose_accel", 16'(want.accel),      16'(pose_out.pose_accel));
        check_field("seq_done",   16'(want.done),       16'(pose_out.seq_done));
      end
    end
  end

  // Random receiver back-pressure in bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      pose_out.ready <= 1'b0;
      stall_left     <= stall_left - 1;
    end else if (receiver_stalls && $urandom_range(0, 9) == 0) begin
      pose_out.ready <= 1'b0;
      stall_left     <= $urandom_range(0, 13);
    end else begin
      pose_out.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((seq_in.valid && seq_in.ready) || (pose_out.valid && pose_out.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("FAIL timed_pose_sequencer");
        $finish;
      end
    end
  end

  // Ticks, restart and the spare code with an empty table
  task automatic test_empty_table();
    send_item(make_item(CMD_TICK, '0, '0, 16'd5));
    send_item(make_item(CmdSpare, '0, '0, '0));
    send_item(make_item(CMD_RESTART, '0, '0, '0));
  endtask

  task automatic test_entry_extremes();
    send_item(make_item(CMD_WRITE, 4'd0, '{left: 16'sh8000, right: 16'sh7FFF,
              speed: 16'hFFFF, accel: 8'hFF, hold: 16'h0000}, '0));
    send_item(make_item(CMD_WRITE, 4'd1, '{left: 16'sh7FFF, right: 16'sh8000,
              speed: 16'h0000, accel: 8'h00, hold: 16'hFFFF}, '0));
    send_item(make_item(CMD_WRITE, 4'd2, '{left: 16'shFFFF, right: 16'sh0000,
              speed: 16'h5555, accel: 8'hAA, hold: 16'd10}, '0));
    send_item(make_item(CMD_WRITE, 4'd3, '{left: 16'sh0000, right: 16'shFFFF,
              speed: 16'hAAAA, accel: 8'h55, hold: 16'd1}, '0));
  endtask

  // Zero hold, repeated zero ticks, partial ticks and the run finishing
  task automatic test_step_timing();
    drain_poses();
    write_step_count(5'd4);
    send_item(make_item(CMD_TICK, '0, '0, 16'd0));
    send_item(make_item(CMD_TICK, '0, '0, 16'd0));
    send_item(make_item(CMD_TICK, '0, '0, 16'd0));
    send_item(make_item(CMD_TICK, '0, '0, 16'hFFFF));
    send_item(make_item(CMD_TICK, '0, '0, 16'd4));
    send_item(make_item(CMD_TICK, '0, '0, 16'd5));
    send_item(make_item(CMD_TICK, '0, '0, 16'd1));
    send_item(make_item(CMD_TICK, '0, '0, 16'hFFFF));
    send_item(make_item(CMD_TICK, '0, '0, 16'd7));
  endtask

  task automatic test_restart_and_spare();
    send_item(make_item(CMD_RESTART, '0, '0, '0));
    send_item(make_item(CMD_TICK, '0, '0, 16'd3));
    send_item(make_item(CmdSpare, 4'hF, '1, 16'hFFFF));
  endtask

  // Lower the step count beneath the pointer, then empty the run
  task automatic test_count_change();
    send_item(make_item(CMD_TICK, '0, '0, 16'hFFFF));
    drain_poses();
    write_step_count(5'd1);
    send_item(make_item(CMD_TICK, '0, '0, 16'd2));
    drain_poses();
    write_step_count(5'd0);
    send_item(make_item(CMD_TICK, '0, '0, 16'd2));
  endtask

  task automatic test_full_table();
    for (int i = 0; i < MAX_STEPS; i++)
      send_item(make_item(CMD_WRITE, 4'(i), random_entry(), pick_tick()));
  endtask

  task automatic test_random_phase(input int unsigned phase, input bit quiet);
    logic [4:0] count;
    case (phase)
      0: count = 5'd16;
      1: count = 5'd1;
      2: count = 5'd0;
      3: count = 5'd31;
      4: count = 5'd17;
      default: begin
        if ($urandom_range(0, 6) == 0) count = 5'($urandom_range(0, 31));
        else                           count = 5'($urandom_range(1, 16));
      end
    endcase
    drain_poses();
    if (quiet) {sender_gaps, receiver_stalls} = 2'b00;
    else       {sender_gaps, receiver_stalls} = 2'($urandom_range(0, 3));
    write_step_count(count);
    send_item(make_item(CMD_RESTART, '0, '0, '0));
    repeat (PhaseItems) begin
      if ($urandom_range(0, 149) == 0) drain_poses();
      send_item(random_item());
    end
  endtask

  initial begin
    rst_ni             <= 1'b0;
    cfg_if.valid       <= 1'b0;
    cfg_if.data        <= '0;
    seq_in.valid       <= 1'b0;
    seq_in.cmd         <= '0;
    seq_in.entry_index <= '0;
    seq_in.entry_left  <= '0;
    seq_in.entry_right <= '0;
    seq_in.entry_speed <= '0;
    seq_in.entry_accel <= '0;
    seq_in.entry_hold  <= '0;
    seq_in.tick_ms     <= '0;
    step_ptr   = '0;
    step_ms    = '0;
    step_total = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_entry_extremes();
    test_step_timing();
    test_restart_and_spare();
    test_count_change();
    test_full_table();
    for (int p = 0; p < PhaseCount; p++)
      test_random_phase(p, p >= PhaseCount - 2);

    drain_poses();
    repeat (4) @(posedge clk_i);
    if (errors == 0 && pending_poses.size() == 0) begin
      $display("PASS timed_pose_sequencer");
    end else begin
      $display("FAIL timed_pose_sequencer");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/tps_pkg.sv
rtl/core/tps_if.sv
rtl/core/timed_pose_sequencer.sv
tb/tb_timed_pose_sequencer.sv
